// ===== src/iprg_pkg.sv =====
// ----------------------------------------------------------------------------
// iprg_pkg: shared types and constants for the IPv4 range group matcher
// Payload structs, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package iprg_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 9;
    localparam int unsigned CountW   = 9;

    localparam logic [CfgIdxW-1:0] REG_INC_ALL = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_EXC_ALL = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_INC_G0  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_EXC_G0  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_INC_G1  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_EXC_G1  = 3'd5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic        mode;
        logic        group;
        logic        which_list;
        logic [7:0]  entry_index;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [31:0] address;
    } in_item_t;

    typedef struct packed {
        logic included;
        logic in_include_list;
        logic in_exclude_list;
    } out_item_t;

    // classified query handed from front to back
    typedef struct packed {
        logic              group;
        logic [31:0]       address;
        logic [CountW-1:0] inc_n;
        logic [CountW-1:0] exc_n;
        logic              inc_all;
        logic              exc_all;
    } query_t;

endpackage

// ===== src/ip_range_group_match.sv =====
// ----------------------------------------------------------------------------
// ip_range_group_match: IPv4 address-group range classifier
// Two groups, each with sorted include and exclude range lists.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------
//   in       | in_valid / in_ready   | in_item  (write or query)
//   out      | out_valid / out_ready | out_item (query result)
//   cfg      | cfg_we                | cfg_index, cfg_data
//
// A write beat gives no result, and waits until every earlier query has
// left the queue and finished its search. A query is searched in both
// lists side by side, the longer list taking at most log2(MAX_RANGES)+1
// probes; each probe is one registered read of the range memories. The
// search unit takes no new query until it has finished the last one. A
// two-entry queue lets queries be taken while a search runs. Reset clears
// registers, the table is undefined until written. A stalled output holds
// the search unit.
// ----------------------------------------------------------------------------
module ip_range_group_match #(
    parameter int unsigned MAX_RANGES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [iprg_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [iprg_pkg::CfgDataW-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  iprg_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output iprg_pkg::out_item_t             out_item
);
    import iprg_pkg::*;

    localparam int unsigned IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic            wr_en, wr_list, wr_group;
    logic [IdxW-1:0] wr_index;
    logic [31:0]     wr_start, wr_end;
    logic            fq_valid, fq_ready, bq_valid, bq_ready;
    logic            back_busy;
    query_t          fq_item, bq_item;

    iprg_front #(.MAX_RANGES(MAX_RANGES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .hold_writes(bq_valid || back_busy),
        .wr_en(wr_en), .wr_list(wr_list), .wr_group(wr_group),
        .wr_index(wr_index), .wr_start(wr_start), .wr_end(wr_end),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    iprg_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(fq_valid), .push_ready(fq_ready), .push_item(fq_item),
        .pop_valid(bq_valid), .pop_ready(bq_ready), .pop_item(bq_item)
    );

    iprg_back #(.MAX_RANGES(MAX_RANGES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_list(wr_list), .wr_group(wr_group),
        .wr_index(wr_index), .wr_start(wr_start), .wr_end(wr_end),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_item(bq_item),
        .busy(back_busy),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

endmodule

// ===== src/iprg_front.sv =====
// ----------------------------------------------------------------------------
// iprg_front: accept and classify beats
// Holds the configuration registers, hands query beats to the queue with the
// group's counts and flags attached, and passes write beats out as table
// writes.
// ----------------------------------------------------------------------------
module iprg_front #(
    parameter int unsigned MAX_RANGES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [iprg_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [iprg_pkg::CfgDataW-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  iprg_pkg::in_item_t              in_item,
    input  logic                            hold_writes,
    output logic                            wr_en,
    output logic                            wr_list,
    output logic                            wr_group,
    output logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] wr_index,
    output logic [31:0]                     wr_start,
    output logic [31:0]                     wr_end,
    output logic                            q_valid,
    input  logic                            q_ready,
    output iprg_pkg::query_t                q_item
);
    import iprg_pkg::*;

    localparam int unsigned IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic [1:0]        inc_all_reg, exc_all_reg;
    logic [CountW-1:0] inc_g0_reg, exc_g0_reg, inc_g1_reg, exc_g1_reg;
    logic              is_query;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_all_reg <= '0;
            exc_all_reg <= '0;
            inc_g0_reg  <= '0;
            exc_g0_reg  <= '0;
            inc_g1_reg  <= '0;
            exc_g1_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INC_ALL: inc_all_reg <= cfg_data[1:0];
                REG_EXC_ALL: exc_all_reg <= cfg_data[1:0];
                REG_INC_G0:  inc_g0_reg  <= cfg_data;
                REG_EXC_G0:  exc_g0_reg  <= cfg_data;
                REG_INC_G1:  inc_g1_reg  <= cfg_data;
                REG_EXC_G1:  exc_g1_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign is_query = (in_item.mode == MODE_QUERY);
    // hold writes until earlier queries have finished searching;
    // queries wait for queue space
    assign in_ready = is_query ? q_ready : !hold_writes;
    assign accept   = in_valid && in_ready;

    assign q_valid = in_valid && is_query;

    always_comb
    begin
        q_item.group   = in_item.group;
        q_item.address = in_item.address;
        q_item.inc_n   = in_item.group ? inc_g1_reg : inc_g0_reg;
        q_item.exc_n   = in_item.group ? exc_g1_reg : exc_g0_reg;
        q_item.inc_all = in_item.group ? inc_all_reg[1] : inc_all_reg[0];
        q_item.exc_all = in_item.group ? exc_all_reg[1] : exc_all_reg[0];
    end

    // drop writes beyond the table
    assign wr_en    = accept && !is_query && ({24'd0, in_item.entry_index} < 32'(MAX_RANGES));
    assign wr_list  = in_item.which_list;
    assign wr_group = in_item.group;
    assign wr_index = IdxW'(in_item.entry_index);
    assign wr_start = in_item.range_start;
    assign wr_end   = in_item.range_end;

endmodule

// ===== src/iprg_queue.sv =====
// ----------------------------------------------------------------------------
// iprg_queue: two-entry queue between front and back
// Lets the front take beats while the back searches.
// ----------------------------------------------------------------------------
module iprg_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  iprg_pkg::query_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output iprg_pkg::query_t pop_item
);
    import iprg_pkg::*;

    query_t     mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_item   = mem_reg[rp_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> cnt_reg != 2'd2)
        else $error("queue grew by two in a cycle");

endmodule

// ===== src/iprg_back.sv =====
// ----------------------------------------------------------------------------
// iprg_back: binary search of the include and exclude lists
// Both lists of the group are searched side by side, one probe per memory
// read, then the end check of the stopping entry and the combine rule.
// ----------------------------------------------------------------------------
module iprg_back #(
    parameter int unsigned MAX_RANGES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic                            wr_list,
    input  logic                            wr_group,
    input  logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] wr_index,
    input  logic [31:0]                     wr_start,
    input  logic [31:0]                     wr_end,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  iprg_pkg::query_t                q_item,
    output logic                            busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output iprg_pkg::out_item_t             out_item
);
    import iprg_pkg::*;

    localparam int unsigned IdxW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned PosW = IdxW + 2;     // signed search bounds
    localparam int unsigned AddrW = IdxW + 1;    // group plus index per list
    localparam int unsigned MemDepth = 2 << IdxW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_READ,
        S_FETCH,
        S_CHECK
    } state_t;

    // one start/end memory per list; address = {group, index}
    logic [31:0] inc_start_mem [MemDepth];
    logic [31:0] inc_end_mem   [MemDepth];
    logic [31:0] exc_start_mem [MemDepth];
    logic [31:0] exc_end_mem   [MemDepth];

    state_t state_reg;
    query_t q_reg;
    query_t q_clip;
    logic signed [PosW-1:0] ilo_reg, ihi_reg, elo_reg, ehi_reg;
    logic signed [PosW-1:0] imid, emid;
    logic iact_reg, eact_reg, ihit_reg, ehit_reg;
    logic [AddrW-1:0] ird_addr, erd_addr;
    logic [31:0] is_rd_reg, ie_rd_reg, es_rd_reg, ee_rd_reg;
    logic [CountW-1:0] inc_cl, exc_cl;
    logic out_valid_reg;
    out_item_t out_reg;
    logic ires, eres, ip_inc, ip_exc, res;
    logic signed [PosW-1:0] ilo_next, ihi_next, elo_next, ehi_next;
    logic iact_next, eact_next, ihit_next, ehit_next;

    assign imid = (ilo_reg + ihi_reg) >>> 1;
    assign emid = (elo_reg + ehi_reg) >>> 1;

    always_comb
    begin
        if (state_reg == S_PROBE)
        begin
            ird_addr = {q_reg.group, imid[IdxW-1:0]};
            erd_addr = {q_reg.group, emid[IdxW-1:0]};
        end
        else
        begin
            ird_addr = {q_reg.group, ihi_reg[IdxW-1:0]};
            erd_addr = {q_reg.group, ehi_reg[IdxW-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_list)
        begin
            inc_start_mem[{wr_group, wr_index}] <= wr_start;
            inc_end_mem[{wr_group, wr_index}]   <= wr_end;
        end
        if (wr_en && wr_list)
        begin
            exc_start_mem[{wr_group, wr_index}] <= wr_start;
            exc_end_mem[{wr_group, wr_index}]   <= wr_end;
        end
        is_rd_reg <= inc_start_mem[ird_addr];
        ie_rd_reg <= inc_end_mem[ird_addr];
        es_rd_reg <= exc_start_mem[erd_addr];
        ee_rd_reg <= exc_end_mem[erd_addr];
    end

    assign inc_cl = (32'(q_item.inc_n) > MAX_RANGES) ? CountW'(MAX_RANGES) : q_item.inc_n;
    assign exc_cl = (32'(q_item.exc_n) > MAX_RANGES) ? CountW'(MAX_RANGES) : q_item.exc_n;

    always_comb
    begin
        q_clip       = q_item;
        q_clip.inc_n = inc_cl;
        q_clip.exc_n = exc_cl;
    end

    // one probe step per list on the data read last cycle
    always_comb
    begin
        ilo_next = ilo_reg;
        ihi_next = ihi_reg;
        elo_next = elo_reg;
        ehi_next = ehi_reg;
        iact_next = iact_reg;
        eact_next = eact_reg;
        ihit_next = ihit_reg;
        ehit_next = ehit_reg;
        if (iact_reg)
        begin
            if (q_reg.address < is_rd_reg)
            begin
                ihi_next = imid - PosW'(1);
            end
            else if (q_reg.address > is_rd_reg)
            begin
                ilo_next = imid + PosW'(1);
            end
            else
            begin
                ihit_next = 1'b1;
            end
            if (q_reg.address == is_rd_reg || ilo_next > ihi_next)
            begin
                iact_next = 1'b0;
            end
        end
        if (eact_reg)
        begin
            if (q_reg.address < es_rd_reg)
            begin
                ehi_next = emid - PosW'(1);
            end
            else if (q_reg.address > es_rd_reg)
            begin
                elo_next = emid + PosW'(1);
            end
            else
            begin
                ehit_next = 1'b1;
            end
            if (q_reg.address == es_rd_reg || elo_next > ehi_next)
            begin
                eact_next = 1'b0;
            end
        end
    end

    assign ires = ihit_reg || (!ihi_reg[PosW-1] && iact_reg == 1'b0 && q_reg.inc_n != '0
                  && q_reg.address >= is_rd_reg && q_reg.address <= ie_rd_reg);
    assign eres = ehit_reg || (!ehi_reg[PosW-1] && eact_reg == 1'b0 && q_reg.exc_n != '0
                  && q_reg.address >= es_rd_reg && q_reg.address <= ee_rd_reg);
    assign ip_inc = q_reg.inc_all || ires;
    assign ip_exc = q_reg.exc_all || eres;
    assign res = q_reg.inc_all ? !ip_exc : (q_reg.exc_all ? ip_inc : (ip_inc && !ip_exc));

    assign q_ready   = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            q_reg         <= '0;
            ilo_reg       <= '0;
            ihi_reg       <= '0;
            elo_reg       <= '0;
            ehi_reg       <= '0;
            iact_reg      <= 1'b0;
            eact_reg      <= 1'b0;
            ihit_reg      <= 1'b0;
            ehit_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_CHECK)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        q_reg    <= q_clip;
                        ilo_reg  <= '0;
                        elo_reg  <= '0;
                        ihi_reg  <= PosW'(inc_cl) - PosW'(1);
                        ehi_reg  <= PosW'(exc_cl) - PosW'(1);
                        iact_reg <= (inc_cl != '0);
                        eact_reg <= (exc_cl != '0);
                        ihit_reg <= 1'b0;
                        ehit_reg <= 1'b0;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    // read at mid issued this cycle
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    ilo_reg  <= ilo_next;
                    ihi_reg  <= ihi_next;
                    elo_reg  <= elo_next;
                    ehi_reg  <= ehi_next;
                    iact_reg <= iact_next;
                    eact_reg <= eact_next;
                    ihit_reg <= ihit_next;
                    ehit_reg <= ehit_next;
                    state_reg <= (iact_next || eact_next) ? S_PROBE : S_FETCH;
                end
                S_FETCH:
                begin
                    // read at the final hi issued this cycle
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.included        <= res;
                        out_reg.in_include_list <= ires;
                        out_reg.in_exclude_list <= eres;
                        out_valid_reg           <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (!iact_reg && !eact_reg))
        else $error("end check with a search still running");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |=> (state_reg == S_READ))
        else $error("probe not followed by read");

endmodule
